>>> rtl/core/b64e_pkg.sv
package b64e_pkg;

  // base64 pad character '='
  localparam logic [6:0] PadChar = 7'h3D;

  // most characters one byte can produce (last byte at start of group)
  localparam int unsigned MaxChars = 4;

  // one queued unit of work: the characters of one byte
  typedef struct packed {
    logic [MaxChars-1:0][6:0] chars;     // characters in send order, slot 0 first
    logic [1:0]               last_slot; // slot of the final character
    logic                     eom;       // final character ends the message
  } job_t;

  // queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  // 6-bit value to standard base64 alphabet character
  function automatic logic [6:0] sym(input logic [5:0] idx);
    logic [6:0] wide;
    wide = {1'b0, idx};
    if (idx < 6'd26) begin
      return wide + 7'd65;
    end else if (idx < 6'd52) begin
      return wide + 7'd71;
    end else if (idx < 6'd62) begin
      return wide - 7'd4;
    end else if (idx == 6'd62) begin
      return 7'd43;
    end else begin
      return 7'd47;
    end
  endfunction

endpackage

>>> rtl/core/b64e_front.sv
module b64e_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           in_byte_i,
  input  logic                 last_byte_i,
  input  b64e_pkg::fifo_status_t fifo_st_i,
  output logic                 push_o,
  output b64e_pkg::job_t       job_o
);

  localparam logic [1:0] PhaseFirst  = 2'd0;
  localparam logic [1:0] PhaseSecond = 2'd1;
  localparam logic [1:0] PhaseThird  = 2'd2;

  logic [1:0] phase_q, phase_d;
  logic [3:0] carry_q, carry_d;
  logic       accept;

  assign in_ready_o = !fifo_st_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept;

  // split the byte into characters and advance the group position
  always_comb begin
    job_o           = '0;
    job_o.eom       = last_byte_i;
    phase_d         = phase_q;
    carry_d         = carry_q;
    unique case (phase_q)
      PhaseSecond: begin
        job_o.chars[0] = b64e_pkg::sym({carry_q[1:0], in_byte_i[7:4]});
        if (last_byte_i) begin
          job_o.chars[1]  = b64e_pkg::sym({in_byte_i[3:0], 2'b00});
          job_o.chars[2]  = b64e_pkg::PadChar;
          job_o.last_slot = 2'd2;
        end else begin
          job_o.last_slot = 2'd0;
        end
        carry_d = in_byte_i[3:0];
        phase_d = PhaseThird;
      end
      PhaseThird: begin
        job_o.chars[0]  = b64e_pkg::sym({carry_q, in_byte_i[7:6]});
        job_o.chars[1]  = b64e_pkg::sym(in_byte_i[5:0]);
        job_o.last_slot = 2'd1;
        carry_d         = '0;
        phase_d         = PhaseFirst;
      end
      default: begin
        job_o.chars[0] = b64e_pkg::sym(in_byte_i[7:2]);
        if (last_byte_i) begin
          job_o.chars[1]  = b64e_pkg::sym({in_byte_i[1:0], 4'b0000});
          job_o.chars[2]  = b64e_pkg::PadChar;
          job_o.chars[3]  = b64e_pkg::PadChar;
          job_o.last_slot = 2'd3;
        end else begin
          job_o.last_slot = 2'd0;
        end
        carry_d = {2'b00, in_byte_i[1:0]};
        phase_d = PhaseSecond;
      end
    endcase
    // message end restarts the group
    if (last_byte_i) begin
      carry_d = '0;
      phase_d = PhaseFirst;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhaseFirst;
      carry_q <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      carry_q <= carry_d;
    end
  end

endmodule

>>> rtl/core/b64e_fifo.sv
module b64e_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  b64e_pkg::job_t         push_job_i,
  input  logic                   pop_i,
  output b64e_pkg::job_t         head_o,
  output b64e_pkg::fifo_status_t status_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  b64e_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign status_o.full  = (count_q == CntW'(Depth));
  assign status_o.empty = (count_q == '0);
  assign head_o         = mem_q[rd_ptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/b64e_back.sv
module b64e_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  b64e_pkg::job_t         head_i,
  input  b64e_pkg::fifo_status_t fifo_st_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [6:0]             out_char_o,
  output logic                   end_of_message_o
);

  logic [1:0] slot_q;
  logic       valid_q;
  logic [6:0] char_q;
  logic       eom_q;
  logic       load;
  logic       final_slot;

  // output register takes a new character when empty or being drained
  assign load       = (!valid_q || out_ready_i) && !fifo_st_i.empty;
  assign final_slot = (slot_q == head_i.last_slot);
  assign pop_o      = load && final_slot;

  assign out_valid_o      = valid_q;
  assign out_char_o       = char_q;
  assign end_of_message_o = eom_q;

  // character payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= head_i.chars[slot_q];
      eom_q  <= head_i.eom && final_slot;
    end
  end

  // slot walk and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        slot_q  <= final_slot ? '0 : slot_q + 1'b1;
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/core/base64_stream_encoder_top.sv
// Streaming base64 encoder, standard alphabet with '=' padding. One plain byte
// per input beat, with last_byte_i marking the end of a message; one ASCII
// character per output beat, with end_of_message_o on the final one. A byte
// yields one character at the first or second place of a 3-byte group, two at
// the third, and on a last byte the partial group is closed with one or two
// pad characters (up to four characters for that byte). The output register
// sends one character per cycle while out_ready_i keeps draining it. Bytes
// are taken while the QueueDepth-entry queue between the input side and the
// output serializer has room, so the input keeps moving while characters wait
// on the output. An accepted byte's characters are written into the queue
// first and then loaded into the output register one by one, once the
// characters ahead of them have gone.
module base64_stream_encoder_top #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [6:0] out_char_o,
  output logic       end_of_message_o
);

  b64e_pkg::job_t         push_job;
  b64e_pkg::job_t         head_job;
  b64e_pkg::fifo_status_t fifo_st;
  logic                   push;
  logic                   pop;

  // byte intake and character split
  b64e_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_byte_i   (in_byte_i),
    .last_byte_i (last_byte_i),
    .fifo_st_i   (fifo_st),
    .push_o      (push),
    .job_o       (push_job)
  );

  // work queue
  b64e_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .head_o     (head_job),
    .status_o   (fifo_st)
  );

  // character serializer
  b64e_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_i           (head_job),
    .fifo_st_i        (fifo_st),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_char_o       (out_char_o),
    .end_of_message_o (end_of_message_o)
  );

  // queue never takes a beat while full
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push && fifo_st.full))
    else $error("push into full queue");

  // queue never pops while empty
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(pop && fifo_st.empty))
    else $error("pop from empty queue");

  // an accepted byte leaves work in the queue on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |=> !fifo_st.empty)
    else $error("accepted byte lost from queue");

endmodule

>>> sim/tb_base64_stream_encoder_top.sv
`timescale 1ns / 100ps

module tb_base64_stream_encoder_top;

  // standard alphabet, character i sits at bits [8*(63-i) +: 8]
  localparam logic [8*64-1:0] Alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  // traffic modes, switched by the number of accepted bytes
  localparam int unsigned ModeOneEnd   = 140;
  localparam int unsigned ModeTwoEnd   = 280;
  localparam int unsigned HoldStart    = 300;
  localparam int unsigned HoldCycles   = 60;
  localparam int unsigned TargetBytes  = 420;
  localparam int unsigned DrainCycles  = 12;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } plain_beat_t;

  typedef struct packed {
    logic [6:0] ch;
    logic       eom;
  } char_beat_t;

  logic       clk_i            = 1'b0;
  logic       rst_ni           = 1'b0;
  logic       in_valid_i       = 1'b0;
  logic       in_ready_o;
  logic [7:0] in_byte_i        = 8'h00;
  logic       last_byte_i      = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i      = 1'b0;
  logic [6:0] out_char_o;
  logic       end_of_message_o;

  plain_beat_t pending_bytes[$];
  char_beat_t  expected_chars[$];

  // encoder state mirror
  logic [1:0] group_pos = 2'd0;
  logic [3:0] leftover  = 4'd0;

  int unsigned bytes_accepted = 0;
  int unsigned error_count    = 0;
  int unsigned hold_left      = 0;
  bit          hold_done      = 1'b0;

  base64_stream_encoder_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .in_byte_i        (in_byte_i),
    .last_byte_i      (last_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_char_o       (out_char_o),
    .end_of_message_o (end_of_message_o)
  );

  // clock and reset
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic logic [6:0] b64_char(input logic [5:0] idx);
    logic [7:0] code;
    code = Alphabet[8*(63-idx) +: 8];
    return code[6:0];
  endfunction

  function automatic void push_char(input logic [6:0] ch, input logic eom);
    char_beat_t c;
    c.ch  = ch;
    c.eom = eom;
    expected_chars.push_back(c);
  endfunction

  // predict the characters of one byte and advance the group state
  function automatic void encode_byte(input plain_beat_t pb);
    logic [7:0] b;
    b = pb.data;
    case (group_pos)
      2'd1: begin
        push_char(b64_char({leftover[1:0], b[7:4]}), 1'b0);
        if (pb.last) begin
          push_char(b64_char({b[3:0], 2'b00}), 1'b0);
          push_char(b64e_pkg::PadChar, 1'b1);
        end else begin
          leftover  = b[3:0];
          group_pos = 2'd2;
        end
      end
      2'd2: begin
        push_char(b64_char({leftover, b[7:6]}), 1'b0);
        push_char(b64_char(b[5:0]), pb.last);
        leftover  = 4'd0;
        group_pos = 2'd0;
      end
      // unused position counts as start of group
      default: begin
        push_char(b64_char(b[7:2]), 1'b0);
        if (pb.last) begin
          push_char(b64_char({b[1:0], 4'b0000}), 1'b0);
          push_char(b64e_pkg::PadChar, 1'b0);
          push_char(b64e_pkg::PadChar, 1'b1);
        end else begin
          leftover  = {2'b00, b[1:0]};
          group_pos = 2'd1;
        end
      end
    endcase
    if (pb.last) begin
      group_pos = 2'd0;
      leftover  = 4'd0;
    end
  endfunction

  function automatic bit sender_gap();
    if (bytes_accepted < ModeOneEnd) return ($urandom_range(0, 99) < 34);
    if (bytes_accepted < ModeTwoEnd) return ($urandom_range(0, 99) < 69);
    return 1'b0;
  endfunction

  function automatic bit receiver_gap();
    if (bytes_accepted < ModeOneEnd) return ($urandom_range(0, 99) < 69);
    if (bytes_accepted < ModeTwoEnd) return ($urandom_range(0, 99) < 34);
    return 1'b0;
  endfunction

  // input driver: take a beat from the pending queue once the last one is gone
  always @(posedge clk_i) begin
    plain_beat_t pb;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        pb.data = in_byte_i;
        pb.last = last_byte_i;
        encode_byte(pb);
        bytes_accepted <= bytes_accepted + 1;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_bytes.size() > 0 && !sender_gap()) begin
          pb = pending_bytes.pop_front();
          in_byte_i   <= pb.data;
          last_byte_i <= pb.last;
          in_valid_i  <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // output side ready, with one long hold-off to back up the queue
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (!hold_done && bytes_accepted >= HoldStart) begin
      hold_done   <= 1'b1;
      hold_left   <= HoldCycles;
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= !receiver_gap();
    end
  end

  // output monitor: compare each character beat with the oldest prediction
  always @(posedge clk_i) begin
    char_beat_t exp_c;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected char beat, expected none, got char %h eom %b",
                 $time, out_char_o, end_of_message_o);
        error_count = error_count + 1;
      end else begin
        exp_c = expected_chars.pop_front();
        if (out_char_o !== exp_c.ch) begin
          $display("%0t: out_char mismatch, expected %h, got %h",
                   $time, exp_c.ch, out_char_o);
          error_count = error_count + 1;
        end
        if (end_of_message_o !== exp_c.eom) begin
          $display("%0t: end_of_message mismatch, expected %b, got %b",
                   $time, exp_c.eom, end_of_message_o);
          error_count = error_count + 1;
        end
      end
    end
  end

  task automatic queue_byte(input logic [7:0] data, input logic last);
    plain_beat_t pb;
    pb.data = data;
    pb.last = last;
    pending_bytes.push_back(pb);
  endtask

  // stimulus and end of run
  initial begin
    int unsigned total;
    int unsigned len;
    logic [7:0]  b;

    // single-byte messages, both extremes
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hFF, 1'b1);
    // two bytes, ends at second place of the group
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b1);
    // three bytes, ends on a full group
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b1);
    // hits both '+' and '/'
    queue_byte(8'hFB, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hBF, 1'b1);
    // group wrap, then last byte at start of next group
    queue_byte(8'h4D, 1'b0);
    queue_byte(8'h61, 1'b0);
    queue_byte(8'h6E, 1'b0);
    queue_byte(8'hA5, 1'b1);
    // group wrap, then last byte at second place
    queue_byte(8'h5A, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'h01, 1'b0);
    queue_byte(8'h7F, 1'b0);
    queue_byte(8'hFE, 1'b1);
    total = pending_bytes.size();

    // random messages, mostly short, now and then long
    while (total < TargetBytes) begin
      if ($urandom_range(0, 9) == 0) len = $urandom_range(10, 24);
      else len = $urandom_range(1, 6);
      for (int unsigned i = 0; i < len; i++) begin
        case ($urandom_range(0, 9))
          0:       b = 8'h00;
          1:       b = 8'hFF;
          default: b = 8'($urandom_range(0, 255));
        endcase
        queue_byte(b, i == len - 1);
      end
      total += len;
    end

    // drain
    while (pending_bytes.size() > 0 || in_valid_i) @(posedge clk_i);
    while (expected_chars.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
